// ===== rtl/prsru_pkg.sv =====
package prsru_pkg;

  localparam int unsigned VERTICES = 1024;
  localparam int unsigned ADDR_W   = $clog2(VERTICES);
  localparam int unsigned CNT_W    = $clog2(VERTICES);
  localparam int unsigned VCNT_W   = 11;
  localparam int unsigned DATA_W   = 32;

  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
  localparam logic [62:0] ONE_Q62 = 63'h4000_0000_0000_0000;

  localparam logic [31:0] ALPHA_RESET = 32'd1825361101;

  // request codes
  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_ENTRY   = 2'd1;
  localparam logic [1:0] REQ_ROW_END = 2'd2;

  // register indexes
  localparam logic [1:0] REG_ALPHA        = 2'd0;
  localparam logic [1:0] REG_PERTURBATION = 2'd1;
  localparam logic [1:0] REG_VERTEX_COUNT = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENT_MUL,
    S_ENT_ACC,
    S_END_MUL,
    S_END_OUT
  } state_e;

endpackage

// ===== rtl/pagerank_sparse_row_update.sv =====
// sequence: a load is written at its accept edge and leaves busy_o low; an entry keeps
// busy_o high through S_ENT_MUL and S_ENT_ACC (read, multiply, accumulate); a row end
// keeps busy_o high through S_END_MUL and S_END_OUT and sets result_valid_o for one cycle
// from S_END_OUT; no new request is taken while busy, held by the rank memory read and the
// single shared 32x32 multiplier; loads one per cycle while idle; the receiver cannot stall
// reset: row sum, row counter and registers return to defaults; rank memory is not cleared
module pagerank_sparse_row_update (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [1:0]              req_type_i,
  input  logic [9:0]              index_i,
  input  logic [31:0]             value_i,
  output logic                    result_valid_o,
  output logic [9:0]              row_index_o,
  output logic [31:0]             rank_value_o,
  output logic                    last_row_o,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_addr_i,
  input  logic [prsru_pkg::DATA_W-1:0] cfg_wdata_i
);
  import prsru_pkg::*;

  state_e state_q, state_d;

  logic [31:0]       alpha_q;
  logic [31:0]       perturbation_q;
  logic [VCNT_W-1:0] vertex_count_q;

  logic [31:0] rank_mem [VERTICES];
  logic [31:0] rd_data_q;
  logic [31:0] value_q;
  logic [63:0] product_q;
  logic [62:0] row_sum_q;
  logic [CNT_W-1:0] row_cnt_q;

  logic        accept;
  logic        in_range;
  logic [31:0] alpha_c;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [62:0] prod_sat;
  logic [63:0] sum_add;
  logic [62:0] sum_sat;
  logic [32:0] res_add;
  logic [31:0] res_sat;
  logic [VCNT_W-1:0] pass_len;
  logic [VCNT_W-1:0] cnt_next;
  logic        is_last;

  assign accept   = start_i && (state_q == S_IDLE);
  assign busy_o   = (state_q != S_IDLE);
  assign in_range = (32'(index_i) < VERTICES);

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q        <= ALPHA_RESET;
      perturbation_q <= '0;
      vertex_count_q <= VCNT_W'(VERTICES);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_ALPHA:        alpha_q        <= cfg_wdata_i[31:0];
        REG_PERTURBATION: perturbation_q <= cfg_wdata_i[31:0];
        REG_VERTEX_COUNT: vertex_count_q <= cfg_wdata_i[VCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // rank memory: write on load, registered read on entry
  always_ff @(posedge clk_i) begin
    if (accept && (req_type_i == REQ_LOAD) && in_range) begin
      rank_mem[index_i[ADDR_W-1:0]] <= value_i;
    end
    if (accept && (req_type_i == REQ_ENTRY)) begin
      rd_data_q <= rank_mem[index_i[ADDR_W-1:0]];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          priority if (req_type_i == REQ_ENTRY && in_range) state_d = S_ENT_MUL;
          else if (req_type_i == REQ_ROW_END)                state_d = S_END_MUL;
          else                                               state_d = S_IDLE;
        end
      end
      S_ENT_MUL: state_d = S_ENT_ACC;
      S_ENT_ACC: state_d = S_IDLE;
      S_END_MUL: state_d = S_END_OUT;
      S_END_OUT: state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // shared multiplier: probability x rank, or alpha x truncated sum
  assign alpha_c = (alpha_q > ONE_Q31) ? ONE_Q31 : alpha_q;
  assign mul_a   = (state_q == S_END_MUL) ? alpha_c : value_q;
  assign mul_b   = (state_q == S_END_MUL) ? row_sum_q[62:31] : rd_data_q;

  always_ff @(posedge clk_i) begin
    if (accept) value_q <= value_i;
    product_q <= 64'(mul_a) * 64'(mul_b);
  end

  assign prod_sat = (product_q > 64'(ONE_Q62)) ? ONE_Q62 : product_q[62:0];
  assign sum_add  = {1'b0, row_sum_q} + {1'b0, prod_sat};
  assign sum_sat  = (sum_add > 64'(ONE_Q62)) ? ONE_Q62 : sum_add[62:0];

  assign res_add  = {1'b0, product_q[62:31]} + {1'b0, perturbation_q};
  assign res_sat  = (res_add > 33'(ONE_Q31)) ? ONE_Q31 : res_add[31:0];

  // zero counts as one, oversize as the full store
  always_comb begin
    if (vertex_count_q == '0)                        pass_len = VCNT_W'(1);
    else if (32'(vertex_count_q) > VERTICES)         pass_len = VCNT_W'(VERTICES);
    else                                             pass_len = vertex_count_q;
  end
  assign cnt_next = VCNT_W'(row_cnt_q) + VCNT_W'(1);
  assign is_last  = (cnt_next >= pass_len);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_sum_q      <= '0;
      row_cnt_q      <= '0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      if (state_q == S_ENT_ACC) begin
        row_sum_q <= sum_sat;
      end else if (state_q == S_END_OUT) begin
        row_sum_q      <= '0;
        row_cnt_q      <= is_last ? '0 : cnt_next[CNT_W-1:0];
        result_valid_o <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_END_OUT) begin
      row_index_o  <= 10'(row_cnt_q);
      rank_value_o <= res_sat;
      last_row_o   <= is_last;
    end
  end

endmodule

// ===== rtl/prsru_checker.sv =====
module prsru_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start_i,
  input logic                    busy_o,
  input logic [1:0]              req_type_i,
  input logic                    result_valid_o,
  input logic [31:0]             rank_value_o
);
  import prsru_pkg::*;

  // a row end request gives its result once S_END_MUL and S_END_OUT have passed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (req_type_i == REQ_ROW_END) |-> ##3 result_valid_o)
    else $error("row end without result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (rank_value_o <= ONE_Q31))
    else $error("rank value above one");

  // loads complete at their accept edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (req_type_i == REQ_LOAD) |=> !busy_o && !result_valid_o)
    else $error("load request held the block");

endmodule

bind pagerank_sparse_row_update prsru_checker u_prsru_checker (.*);
